// ===== rtl/abwu_pkg.sv =====
// Shared constants, types and codes of the ADC block word unpacker.
package abwu_pkg;

    // Buffer depth for one followed block
    localparam int BLOCK_DEPTH = 8;
    localparam int HELD_W      = $clog2(BLOCK_DEPTH + 1);
    localparam int IDX_W       = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;

    // Field widths
    localparam int WORD_W     = 32;
    localparam int TAG_W      = 8;
    localparam int CRATE_W    = 8;
    localparam int SLOT_W     = 5;
    localparam int SIZE_W     = 8;
    localparam int CHAN_W     = 6;
    localparam int SECTOR_W   = 3;
    localparam int CURRENT_W  = 12;
    localparam int TYPE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Queue sizes
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = 2;
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = 2;
    localparam int CNT_W      = 3;

    // Word type codes (type bits masked with 0x6)
    localparam logic [TYPE_W-1:0] TYPE_HEADER  = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_TRAILER = 3'd4;

    // Highest channel that carries a sector current
    localparam logic [CHAN_W-1:0] MAX_SECTOR_CHAN = 6'd5;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_CRATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADC_SLOT  = 2'd1;
    localparam logic [CRATE_W-1:0]   CRATE_RESET   = 8'd4;
    localparam logic [SLOT_W-1:0]    SLOT_RESET    = 5'd13;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CURRENT    = 2'd0,
        KIND_NO_TRAILER = 2'd1,
        KIND_TOO_LONG   = 2'd2,
        KIND_SHORT      = 2'd3
    } kind_t;

    // Commands from the parser to the executor
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_START = 2'd1,
        OP_FLUSH = 2'd2,
        OP_ERROR = 2'd3
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                op;
        kind_t                  kind;
        logic                   then_long;
        logic                   mism;
        logic [SECTOR_W-1:0]    sector;
        logic [CURRENT_W-1:0]   current;
    } cmd_t;

    // Queue status toward the executor
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmdq_head_t;

    // One result item
    typedef struct packed {
        kind_t                  kind;
        logic [SECTOR_W-1:0]    sector;
        logic [CURRENT_W-1:0]   current;
        logic                   mism;
        logic                   last;
    } res_t;

endpackage

// ===== rtl/adc_block_word_unpacker.sv =====
// Top level of the ADC block word unpacker: parser, command queue, executor.
//
// Usage:
//   Input channel: push/full. A readout word with its trigger tag and
//   first-word mark is taken at a clock edge with push high and full low.
//   Result channel: empty/pop. The oldest result sits on kind, sector,
//   current, tag_mismatch and last while empty is low; pop takes it.
//   Configuration: cfg_valid/cfg_ready with cfg_index (0 crate, 1 slot) and
//   cfg_data; cfg_ready is always high. Write only while the block is idle.
// Timing:
//   The parser takes one word per cycle while the four-entry command queue
//   has room. Error results and block readings reach the ports through the
//   command queue and the result queue. Readings leave the single read port
//   of the reading buffer at one per cycle while the result queue has room.
// Reset:
//   Parser returns to idle, queues empty, crate 4 and slot 13. The reading
//   buffer is not cleared; entries are written before they are read.
// Stalls:
//   When pop stays low the result queue fills, the executor waits, the
//   command queue fills and full rises; nothing is dropped.
module adc_block_word_unpacker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [abwu_pkg::WORD_W-1:0]        word,
    input  logic [abwu_pkg::TAG_W-1:0]         trigger_tag,
    input  logic                               first_word,
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         kind,
    output logic [abwu_pkg::SECTOR_W-1:0]      sector,
    output logic [abwu_pkg::CURRENT_W-1:0]     current,
    output logic                               tag_mismatch,
    output logic                               last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [abwu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abwu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                   accept;
    logic                   cmd_valid;
    abwu_pkg::cmd_t         cmd;
    abwu_pkg::cmdq_head_t   head;
    logic                   cmd_pop;
    abwu_pkg::res_t         res_head;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // Parser
    abwu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .word        (word),
        .trigger_tag (trigger_tag),
        .first_word  (first_word),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    // Command queue
    abwu_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_valid),
        .push_cmd (cmd),
        .full     (full),
        .pop      (cmd_pop),
        .head     (head)
    );

    // Executor and result queue
    abwu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .cmd_pop   (cmd_pop),
        .res_pop   (pop),
        .res_empty (empty),
        .res_head  (res_head)
    );

    // Result ports
    assign kind         = res_head.kind;
    assign sector       = res_head.sector;
    assign current      = res_head.current;
    assign tag_mismatch = res_head.mism;
    assign last         = res_head.last;

`ifndef SYNTH
    // An accepted word can only add a command when the queue had room
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> !full)
        else $error("command issued into a full queue");

    // Every popped result of a flush carries a sector in range
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (res_head.kind == abwu_pkg::KIND_CURRENT)) |->
        (sector <= abwu_pkg::SECTOR_W'(5)))
        else $error("sector out of range");

    // Error results carry no reading
    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (res_head.kind != abwu_pkg::KIND_CURRENT)) |->
        ((sector == '0) && (current == '0) && !tag_mismatch))
        else $error("error result with reading fields set");
`endif

endmodule

// ===== rtl/abwu_front.sv =====
// Word parser: tracks headers, block position and trailers, issues commands.
module abwu_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic [abwu_pkg::WORD_W-1:0]        word,
    input  logic [abwu_pkg::TAG_W-1:0]         trigger_tag,
    input  logic                               first_word,
    input  logic                               cfg_valid,
    input  logic [abwu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [abwu_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               cmd_valid,
    output abwu_pkg::cmd_t                     cmd
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_BLOCK = 3'b010,
        PH_ENDED = 3'b100
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [abwu_pkg::SIZE_W-1:0]     expected_reg, expected_next;
    logic [abwu_pkg::SIZE_W-1:0]     seen_reg, seen_next;
    logic [abwu_pkg::CRATE_W-1:0]    crate_reg;
    logic [abwu_pkg::SLOT_W-1:0]     slot_reg;

    phase_t                          ph;
    logic [abwu_pkg::SIZE_W-1:0]     seen_eff;
    logic [abwu_pkg::SIZE_W-1:0]     expected_eff;
    logic [abwu_pkg::TYPE_W-1:0]     wtype;
    logic [abwu_pkg::SIZE_W-1:0]     size;
    logic [abwu_pkg::CHAN_W-1:0]     chan;
    logic                            is_zero;
    logic                            hdr_match;
    logic                            too_long;

    // Word decode
    always_comb
    begin
        wtype     = {word[26:25], 1'b0};
        size      = word[15:8];
        chan      = word[21:16];
        is_zero   = (word == '0);
        hdr_match = (wtype == abwu_pkg::TYPE_HEADER) && (word[23:16] == crate_reg)
                    && (word[31:27] == slot_reg);
        too_long  = (size > abwu_pkg::SIZE_W'(abwu_pkg::BLOCK_DEPTH));
        // first_word clears the parser before this word
        ph           = first_word ? PH_IDLE : phase_reg;
        seen_eff     = first_word ? '0 : seen_reg;
        expected_eff = first_word ? '0 : expected_reg;
    end

    // Parser step
    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        seen_next     = seen_reg;
        cmd_valid     = 1'b0;
        cmd.op        = abwu_pkg::OP_HOLD;
        cmd.kind      = abwu_pkg::KIND_CURRENT;
        cmd.then_long = 1'b0;
        cmd.mism      = (word[7:0] != trigger_tag);
        cmd.sector    = chan[abwu_pkg::SECTOR_W-1:0];
        cmd.current   = word[abwu_pkg::CURRENT_W-1:0];
        if (accept)
        begin
            phase_next    = ph;
            expected_next = expected_eff;
            seen_next     = seen_eff;
            case (ph)
                PH_BLOCK:
                begin
                    if (seen_eff >= expected_eff)
                    begin
                        phase_next = PH_IDLE;
                        cmd_valid  = 1'b1;
                        if (wtype == abwu_pkg::TYPE_TRAILER)
                        begin
                            cmd.op = abwu_pkg::OP_FLUSH;
                        end
                        else
                        begin
                            // missing trailer; same word seen again outside a block
                            cmd.op   = abwu_pkg::OP_ERROR;
                            cmd.kind = abwu_pkg::KIND_NO_TRAILER;
                            if (is_zero)
                            begin
                                phase_next = PH_ENDED;
                            end
                            else if (hdr_match)
                            begin
                                if (too_long)
                                begin
                                    cmd.then_long = 1'b1;
                                end
                                else
                                begin
                                    phase_next    = PH_BLOCK;
                                    expected_next = size;
                                    seen_next     = '0;
                                end
                            end
                        end
                    end
                    else if (is_zero)
                    begin
                        phase_next = PH_IDLE;
                        cmd_valid  = 1'b1;
                        cmd.op     = abwu_pkg::OP_ERROR;
                        cmd.kind   = abwu_pkg::KIND_SHORT;
                    end
                    else
                    begin
                        seen_next = seen_eff + 1'b1;
                        if (chan <= abwu_pkg::MAX_SECTOR_CHAN)
                        begin
                            cmd_valid = 1'b1;
                            cmd.op    = abwu_pkg::OP_HOLD;
                        end
                    end
                end
                PH_IDLE:
                begin
                    if (is_zero)
                    begin
                        phase_next = PH_ENDED;
                    end
                    else if (hdr_match)
                    begin
                        cmd_valid = 1'b1;
                        if (too_long)
                        begin
                            cmd.op   = abwu_pkg::OP_ERROR;
                            cmd.kind = abwu_pkg::KIND_TOO_LONG;
                        end
                        else
                        begin
                            cmd.op        = abwu_pkg::OP_START;
                            phase_next    = PH_BLOCK;
                            expected_next = size;
                            seen_next     = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_ENDED;
                end
            endcase
        end
    end

    // State and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            expected_reg <= '0;
            seen_reg     <= '0;
            crate_reg    <= abwu_pkg::CRATE_RESET;
            slot_reg     <= abwu_pkg::SLOT_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
            if (cfg_valid && (cfg_index == abwu_pkg::CFG_ADC_CRATE))
            begin
                crate_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == abwu_pkg::CFG_ADC_SLOT))
            begin
                slot_reg <= cfg_data[abwu_pkg::SLOT_W-1:0];
            end
        end
    end

`ifndef SYNTH
    // Inside a block the word count never passes the header's size
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BLOCK) |-> (seen_reg <= expected_reg))
        else $error("words seen beyond block size");

    // A followed block never exceeds the buffer
    a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BLOCK) |->
        (expected_reg <= abwu_pkg::SIZE_W'(abwu_pkg::BLOCK_DEPTH)))
        else $error("followed block larger than buffer");

    // Only an accepted word issues a command
    a_cmd_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> accept)
        else $error("command without accepted word");
`endif

endmodule

// ===== rtl/abwu_cmd_queue.sv =====
// Short command queue between the parser and the executor.
module abwu_cmd_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  abwu_pkg::cmd_t       push_cmd,
    output logic                 full,
    input  logic                 pop,
    output abwu_pkg::cmdq_head_t head
);

    abwu_pkg::cmd_t                     entry_reg [abwu_pkg::CMDQ_DEPTH];
    logic [abwu_pkg::CMDQ_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [abwu_pkg::CMDQ_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [abwu_pkg::CNT_W-1:0]         count_reg, count_next;
    logic                               do_push, do_pop;

    // Pointer and count update
    always_comb
    begin
        full        = (count_reg == abwu_pkg::CNT_W'(abwu_pkg::CMDQ_DEPTH));
        head.valid  = (count_reg != '0);
        head.cmd    = entry_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = pop && head.valid;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + abwu_pkg::CNT_W'(do_push) - abwu_pkg::CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    // Count follows the pointers
    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != abwu_pkg::CNT_W'(abwu_pkg::CMDQ_DEPTH)) |->
        (abwu_pkg::CMDQ_PTR_W'(count_reg) == abwu_pkg::CMDQ_PTR_W'(wr_ptr_reg - rd_ptr_reg)))
        else $error("command queue count out of step");

    // Count never exceeds the depth
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= abwu_pkg::CNT_W'(abwu_pkg::CMDQ_DEPTH))
        else $error("command queue overflow");

    // A push into a full queue leaves the count unchanged unless popped
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> (count_reg == abwu_pkg::CNT_W'(abwu_pkg::CMDQ_DEPTH)))
        else $error("full queue lost an entry");
`endif

endmodule

// ===== rtl/abwu_back.sv =====
// Executor: holds block readings, emits results into the result queue.
module abwu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  abwu_pkg::cmdq_head_t head,
    output logic                 cmd_pop,
    input  logic                 res_pop,
    output logic                 res_empty,
    output abwu_pkg::res_t       res_head
);

    typedef enum logic [2:0] {
        ST_CMD   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_LONG  = 3'b100
    } state_t;

    state_t                                 state_reg, state_next;
    logic [abwu_pkg::HELD_W-1:0]            held_reg, held_next;
    logic [abwu_pkg::HELD_W-1:0]            idx_reg, idx_next;
    logic                                   mism_reg, mism_next;
    logic                                   rd_valid_reg, rd_valid_next;
    logic                                   rd_last_reg, rd_last_next;
    logic [abwu_pkg::SECTOR_W+abwu_pkg::CURRENT_W-1:0] rd_data_reg;
    logic [abwu_pkg::SECTOR_W+abwu_pkg::CURRENT_W-1:0] held_mem [abwu_pkg::BLOCK_DEPTH];

    logic                                   mem_we, mem_re;
    logic [abwu_pkg::IDX_W-1:0]             mem_waddr, mem_raddr;

    abwu_pkg::res_t                         res_mem [abwu_pkg::RES_DEPTH];
    logic [abwu_pkg::RES_PTR_W-1:0]         res_wr_reg, res_rd_reg;
    logic [abwu_pkg::CNT_W-1:0]             res_count_reg, res_count_next;
    logic                                   res_we, res_re;
    abwu_pkg::res_t                         res_wdata;
    logic                                   room;

    // Executor control
    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        idx_next      = idx_reg;
        mism_next     = mism_reg;
        rd_valid_next = 1'b0;
        rd_last_next  = rd_last_reg;
        cmd_pop       = 1'b0;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = held_reg[abwu_pkg::IDX_W-1:0];
        mem_raddr     = idx_reg[abwu_pkg::IDX_W-1:0];
        // a slot is kept free for a reading in flight
        room = (int'(res_count_reg) + int'(rd_valid_reg)) < abwu_pkg::RES_DEPTH;

        // reading fetched last cycle goes out first
        res_we            = rd_valid_reg;
        res_wdata.kind    = abwu_pkg::KIND_CURRENT;
        res_wdata.sector  = rd_data_reg[abwu_pkg::SECTOR_W+abwu_pkg::CURRENT_W-1:
                                        abwu_pkg::CURRENT_W];
        res_wdata.current = rd_data_reg[abwu_pkg::CURRENT_W-1:0];
        res_wdata.mism    = mism_reg;
        res_wdata.last    = rd_last_reg;

        case (state_reg)
            ST_CMD:
            begin
                if (head.valid)
                begin
                    case (head.cmd.op)
                        abwu_pkg::OP_HOLD:
                        begin
                            cmd_pop = 1'b1;
                            if (held_reg < abwu_pkg::HELD_W'(abwu_pkg::BLOCK_DEPTH))
                            begin
                                mem_we    = 1'b1;
                                held_next = held_reg + 1'b1;
                            end
                        end
                        abwu_pkg::OP_START:
                        begin
                            cmd_pop   = 1'b1;
                            held_next = '0;
                        end
                        abwu_pkg::OP_FLUSH:
                        begin
                            cmd_pop = 1'b1;
                            if (held_reg != '0)
                            begin
                                mism_next  = head.cmd.mism;
                                idx_next   = '0;
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            // error results wait for the result path to be free
                            if (room && !rd_valid_reg)
                            begin
                                cmd_pop           = 1'b1;
                                held_next         = '0;
                                res_we            = 1'b1;
                                res_wdata.kind    = head.cmd.kind;
                                res_wdata.sector  = '0;
                                res_wdata.current = '0;
                                res_wdata.mism    = 1'b0;
                                res_wdata.last    = !head.cmd.then_long;
                                if (head.cmd.then_long)
                                begin
                                    state_next = ST_LONG;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                if (room)
                begin
                    mem_re        = 1'b1;
                    rd_valid_next = 1'b1;
                    rd_last_next  = ((idx_reg + 1'b1) == held_reg);
                    idx_next      = idx_reg + 1'b1;
                    if ((idx_reg + 1'b1) == held_reg)
                    begin
                        held_next  = '0;
                        state_next = ST_CMD;
                    end
                end
            end
            ST_LONG:
            begin
                if (room && !rd_valid_reg)
                begin
                    res_we            = 1'b1;
                    res_wdata.kind    = abwu_pkg::KIND_TOO_LONG;
                    res_wdata.sector  = '0;
                    res_wdata.current = '0;
                    res_wdata.mism    = 1'b0;
                    res_wdata.last    = 1'b1;
                    state_next        = ST_CMD;
                end
            end
            default:
            begin
                state_next = ST_CMD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CMD;
            held_reg     <= '0;
            idx_reg      <= '0;
            mism_reg     <= 1'b0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            idx_reg      <= idx_next;
            mism_reg     <= mism_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
        end
    end

    // Reading buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            held_mem[mem_waddr] <= {head.cmd.sector, head.cmd.current};
        end
        if (mem_re)
        begin
            rd_data_reg <= held_mem[mem_raddr];
        end
    end

    // Result queue
    always_comb
    begin
        res_empty      = (res_count_reg == '0);
        res_head       = res_mem[res_rd_reg];
        res_re         = res_pop && !res_empty;
        res_count_next = res_count_reg + abwu_pkg::CNT_W'(res_we)
                         - abwu_pkg::CNT_W'(res_re);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_reg    <= '0;
            res_rd_reg    <= '0;
            res_count_reg <= '0;
        end
        else
        begin
            if (res_we)
            begin
                res_wr_reg <= res_wr_reg + 1'b1;
            end
            if (res_re)
            begin
                res_rd_reg <= res_rd_reg + 1'b1;
            end
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
        begin
            res_mem[res_wr_reg] <= res_wdata;
        end
    end

`ifndef SYNTH
    // Held readings never exceed the buffer
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= abwu_pkg::HELD_W'(abwu_pkg::BLOCK_DEPTH))
        else $error("held count beyond buffer depth");

    // A reading in flight always has a reserved result slot
    a_res_reserve: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(res_count_reg) + int'(rd_valid_reg)) <= abwu_pkg::RES_DEPTH)
        else $error("result queue overcommitted");

    // Flushing only runs over a non-empty buffer
    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> (held_reg != '0) && (idx_reg < held_reg))
        else $error("flush index outside held readings");

    // Read data arrives only from a flush read
    a_read_origin: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(mem_re))
        else $error("reading without a buffer read");
`endif

endmodule
